// ===== design/ffa_pkg.sv =====
// Shared types and codes for the first-fit arena allocator.
// Depends on nothing; used by first_fit_arena_allocator.
package ffa_pkg;

    // Status codes returned with each result word
    localparam logic [1:0] STAT_ALLOC   = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_FREED   = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,     // write the single initial free block
        S_IDLE,     // wait for a request
        S_CHK,      // scan one table entry per cycle
        S_NCHK,     // free: look at the next neighbor
        S_MRG,      // free: write merged block, plan table compaction
        S_SDRD,     // compaction: read source entry
        S_SDWR,     // compaction: write it lower
        S_SURD,     // split: read entry to move up
        S_SUWR,     // split: write it one place higher
        S_SPLO,     // split: write the new free remainder
        S_SPHI      // split: write the granted block
    } t_state;

endpackage

// ===== design/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/first_fit_arena_allocator.sv =====
// First-fit arena allocator: block table in one ffa_ram, read-modify-write sequencer.
// Allocate scans entries in order; a split moves later entries up, then writes the free
// remainder and the granted block. Free scans for the block, reads the next neighbor
// unless the hit is the last entry, writes the merged block and compacts on a merge.
// One request at a time, receiver never stalls; busy never lasts past the strobe.
// Sync reset, then S_INIT writes the initial free block (busy high). Uses ffa_pkg.
module first_fit_arena_allocator #(
    parameter int ARENA_BYTES  = 256,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_BLOCKS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [7:0] i_req_size,
    input  logic [7:0] i_payload_addr,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_grant_addr
);

    localparam int AW = $clog2(ARENA_BYTES);          // offset / length width
    localparam int CW = ((AW > 8) ? AW : 8) + 2;      // compare width
    localparam int EW = 2 * AW + 1;                   // entry: {in_use, start, len}
    localparam int IW = $clog2(MAX_BLOCKS);           // table index
    localparam int TW = $clog2(MAX_BLOCKS + 1);       // entry count
    localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] ARENA = CW'(ARENA_BYTES);

    ffa_pkg::t_state r_state, n_state;

    logic [TW-1:0] r_total, n_total;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_j, n_j;
    logic [1:0]    r_rm, n_rm;
    logic          r_op, n_op;
    logic [7:0]    r_size, n_size;
    logic [CW-1:0] r_hdr, n_hdr;
    logic [EW-1:0] r_ent, n_ent;
    logic [EW-1:0] r_prev, n_prev;
    logic [AW-1:0] r_nlen, n_nlen;
    logic          r_nfree, n_nfree;
    logic          r_valid, n_valid;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_grant, n_grant;

    // RAM port
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, rd;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // fields of the entry just read and of held entries
    logic          rd_use;
    logic [AW-1:0] rd_start, rd_len;
    logic [AW-1:0] ent_start, ent_len, prev_start, prev_len;
    logic          prev_use;
    assign rd_use     = rd[2*AW];
    assign rd_start   = rd[2*AW-1:AW];
    assign rd_len     = rd[AW-1:0];
    assign ent_start  = r_ent[2*AW-1:AW];
    assign ent_len    = r_ent[AW-1:0];
    assign prev_use   = r_prev[2*AW];
    assign prev_start = r_prev[2*AW-1:AW];
    assign prev_len   = r_prev[AW-1:0];

    // scan conditions
    logic fit, do_split, last, hit_free, addr_ok, pfree;
    logic [TW:0] idx_next, sd_src;
    logic [CW-1:0] in_hdr;
    assign fit      = !rd_use && (CW'(rd_len) >= CW'(r_size));
    assign do_split = (CW'(rd_len) > CW'(r_size) + HDR + HDR)
                      && (r_total < TW'(MAX_BLOCKS));
    assign idx_next = (TW+1)'(r_idx) + (TW+1)'(1);
    assign last     = idx_next >= (TW+1)'(r_total);
    assign hit_free = rd_use && (CW'(rd_start) == r_hdr);
    assign in_hdr   = CW'(i_payload_addr) - HDR;
    assign addr_ok  = (CW'(i_payload_addr) >= HDR) && (in_hdr < ARENA);
    assign pfree    = (r_idx != '0) && !prev_use;
    assign sd_src   = (TW+1)'(r_j) + (TW+1)'(r_rm);

    // merged lengths
    logic [CW-1:0] len_i, len_p;
    assign len_i = CW'(ent_len) + (r_nfree ? (CW'(r_nlen) + HDR) : '0);
    assign len_p = CW'(prev_len) + len_i + HDR;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffa_pkg::S_INIT: n_state = ffa_pkg::S_IDLE;
            ffa_pkg::S_IDLE: begin
                if (start) begin
                    if (i_op == ffa_pkg::OP_FREE && !addr_ok) begin
                        n_state = ffa_pkg::S_IDLE;
                    end else begin
                        n_state = ffa_pkg::S_CHK;
                    end
                end
            end
            ffa_pkg::S_CHK: begin
                if (r_op == ffa_pkg::OP_ALLOC) begin
                    if (fit) begin
                        n_state = do_split ? ffa_pkg::S_SURD : ffa_pkg::S_IDLE;
                    end else if (last) begin
                        n_state = ffa_pkg::S_IDLE;
                    end
                end else begin
                    if (hit_free) begin
                        n_state = last ? ffa_pkg::S_MRG : ffa_pkg::S_NCHK;
                    end else if (last) begin
                        n_state = ffa_pkg::S_IDLE;
                    end
                end
            end
            ffa_pkg::S_NCHK: n_state = ffa_pkg::S_MRG;
            ffa_pkg::S_MRG: begin
                n_state = (pfree || r_nfree) ? ffa_pkg::S_SDRD : ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_SDRD: begin
                n_state = (sd_src < (TW+1)'(r_total)) ? ffa_pkg::S_SDWR : ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_SDWR: n_state = ffa_pkg::S_SDRD;
            ffa_pkg::S_SURD: begin
                n_state = (r_j == r_idx) ? ffa_pkg::S_SPLO : ffa_pkg::S_SUWR;
            end
            ffa_pkg::S_SUWR: n_state = ffa_pkg::S_SURD;
            ffa_pkg::S_SPLO: n_state = ffa_pkg::S_SPHI;
            ffa_pkg::S_SPHI: n_state = ffa_pkg::S_IDLE;
            default:         n_state = ffa_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM control and result word
    always_comb begin
        n_total   = r_total;
        n_idx     = r_idx;
        n_j       = r_j;
        n_rm      = r_rm;
        n_op      = r_op;
        n_size    = r_size;
        n_hdr     = r_hdr;
        n_ent     = r_ent;
        n_prev    = r_prev;
        n_nlen    = r_nlen;
        n_nfree   = r_nfree;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_grant   = r_grant;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd;
        ram_raddr = IW'(idx_next);
        case (r_state)
            ffa_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {1'b0, AW'(0), AW'(ARENA_BYTES - HEADER_BYTES)};
            end
            ffa_pkg::S_IDLE: begin
                ram_raddr = '0;
                if (start) begin
                    n_op   = i_op;
                    n_size = i_req_size;
                    n_hdr  = in_hdr;
                    n_idx  = '0;
                    if (i_op == ffa_pkg::OP_FREE && !addr_ok) begin
                        n_valid  = 1'b1;
                        n_status = ffa_pkg::STAT_IGNORED;
                        n_grant  = '0;
                    end
                end
            end
            ffa_pkg::S_CHK: begin
                if (r_op == ffa_pkg::OP_ALLOC) begin
                    if (fit) begin
                        n_ent = rd;
                        if (do_split) begin
                            n_j = IW'(r_total - TW'(1));
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            ram_wdata = {1'b1, rd_start, rd_len};
                            n_valid   = 1'b1;
                            n_status  = ffa_pkg::STAT_ALLOC;
                            n_grant   = 8'(CW'(rd_start) + HDR);
                        end
                    end else if (last) begin
                        n_valid  = 1'b1;
                        n_status = ffa_pkg::STAT_NOFIT;
                        n_grant  = '0;
                    end else begin
                        n_idx = IW'(idx_next);
                    end
                end else begin
                    if (hit_free) begin
                        n_ent   = rd;
                        n_nfree = 1'b0;
                    end else if (last) begin
                        n_valid  = 1'b1;
                        n_status = ffa_pkg::STAT_IGNORED;
                        n_grant  = '0;
                    end else begin
                        n_prev = rd;
                        n_idx  = IW'(idx_next);
                    end
                end
            end
            ffa_pkg::S_NCHK: begin
                n_nfree = !rd_use;
                n_nlen  = rd_len;
            end
            ffa_pkg::S_MRG: begin
                ram_we = 1'b1;
                if (pfree) begin
                    ram_waddr = r_idx - IW'(1);
                    ram_wdata = {1'b0, prev_start, AW'(len_p)};
                    n_rm      = r_nfree ? 2'd2 : 2'd1;
                    n_j       = r_idx;
                end else begin
                    ram_waddr = r_idx;
                    ram_wdata = {1'b0, ent_start, AW'(len_i)};
                    n_rm      = r_nfree ? 2'd1 : 2'd0;
                    n_j       = IW'(idx_next);
                end
                if (!pfree && !r_nfree) begin
                    n_valid  = 1'b1;
                    n_status = ffa_pkg::STAT_FREED;
                    n_grant  = '0;
                end
            end
            ffa_pkg::S_SDRD: begin
                ram_raddr = IW'(sd_src);
                if (!(sd_src < (TW+1)'(r_total))) begin
                    n_total  = r_total - TW'(r_rm);
                    n_valid  = 1'b1;
                    n_status = ffa_pkg::STAT_FREED;
                    n_grant  = '0;
                end
            end
            ffa_pkg::S_SDWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = rd;
                n_j       = r_j + IW'(1);
            end
            ffa_pkg::S_SURD: begin
                ram_raddr = r_j;
            end
            ffa_pkg::S_SUWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j + IW'(1);
                ram_wdata = rd;
                n_j       = r_j - IW'(1);
            end
            ffa_pkg::S_SPLO: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + IW'(1);
                ram_wdata = {1'b0,
                             AW'(CW'(ent_start) + HDR + CW'(r_size)),
                             AW'(CW'(ent_len) - CW'(r_size) - HDR)};
            end
            ffa_pkg::S_SPHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {1'b1, ent_start, AW'(r_size)};
                n_total   = r_total + TW'(1);
                n_valid   = 1'b1;
                n_status  = ffa_pkg::STAT_ALLOC;
                n_grant   = 8'(CW'(ent_start) + HDR);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_INIT;
            r_total <= TW'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_rm     <= n_rm;
        r_op     <= n_op;
        r_size   <= n_size;
        r_hdr    <= n_hdr;
        r_ent    <= n_ent;
        r_prev   <= n_prev;
        r_nlen   <= n_nlen;
        r_nfree  <= n_nfree;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    assign busy         = (r_state != ffa_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_grant_addr = r_grant;

endmodule
